// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files of the matrix register unit.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled at the rising clock edge.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/mru_pkg.sv -----
// Shared types and constants of the 4x4 matrix register unit.
// Depends on nothing; used by the float unit, the top level and the checker.
package mru_pkg;

   localparam int unsigned DIM = 4;
   localparam int unsigned ENTRIES = DIM * DIM;
   localparam int unsigned IDX_W = $clog2(DIM);
   localparam int unsigned ADDR_W = $clog2(ENTRIES);
   localparam int unsigned WORD_W = 136;

   localparam logic [31:0] FP_ONE = 32'h3F80_0000;
   localparam logic [31:0] FP_ZERO = 32'h0000_0000;
   localparam logic [31:0] FP_QNAN = 32'hFFC0_0000;

   localparam logic [2:0] REQ_IDENTITY = 3'd0;
   localparam logic [2:0] REQ_LOAD = 3'd1;
   localparam logic [2:0] REQ_READ = 3'd2;
   localparam logic [2:0] REQ_STAGE = 3'd3;
   localparam logic [2:0] REQ_APPLY = 3'd4;

   typedef enum logic {
      FP_MUL = 1'b0,
      FP_ADD = 1'b1
   } fp_op_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL = 5'b00010,
      ST_ADD = 5'b00100,
      ST_OUT = 5'b01000,
      ST_COPY = 5'b10000
   } state_type;

endpackage

// ----- rtl/mru_fpu.sv -----
// Shared single-precision multiply or add unit, round to nearest even.
// Depends on mru_pkg for the operation type and the default NaN.
module mru_fpu (
   input  mru_pkg::fp_op_type op,
   input  logic [31:0]        a,
   input  logic [31:0]        b,
   output logic [31:0]        y
);
   import mru_pkg::*;

   function automatic logic [5:0] lzc50(input logic [49:0] v);
      logic [5:0] n;
      logic       found;
      n = '0;
      found = 1'b0;
      for (int i = 49; i >= 0; i--) begin
         if (!found) begin
            if (v[i]) found = 1'b1;
            else n = n + 6'd1;
         end
      end
      return n;
   endfunction

   // Rounds a mantissa whose integer bit is bit 47 at biased exponent e.
   function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                              input logic [47:0] m, input logic st);
      logic [63:0]        wide;
      logic [63:0]        mask;
      logic [5:0]         sh;
      logic [23:0]        kept;
      logic               g;
      logic               sticky;
      logic               up;
      logic signed [11:0] ee;
      logic [31:0]        res;
      wide = {m, 16'h0};
      sticky = st;
      ee = e;
      sh = '0;
      if (e >= 12'sd255) return {s, 8'hFF, 23'h0};
      if (e <= 12'sd0) begin
         if (e < -12'sd60) sh = 6'd62;
         else sh = 6'(12'sd1 - e);
         mask = (64'd1 << sh) - 64'd1;
         sticky = sticky | (|(wide & mask));
         wide = wide >> sh;
         ee = 12'sd0;
      end
      kept = wide[63:40];
      g = wide[39];
      sticky = sticky | (|wide[38:0]);
      up = g & (sticky | kept[0]);
      res = {1'b0, ee[7:0], kept[22:0]} + {31'd0, up};
      res[31] = s;
      return res;
   endfunction

   logic        sa, sb, sx, sy;
   logic [7:0]  ea, eb, eaf, ebf, exf, eyf, d;
   logic [23:0] ma, mb, mx, my;
   logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
   logic [47:0] prod;
   logic [49:0] pw, bigw, smw, sm, mask, sum, norm;
   logic [5:0]  lz;
   logic        st;
   logic signed [11:0] ex;

   always_comb begin
      sa = a[31];
      sb = b[31];
      ea = a[30:23];
      eb = b[30:23];
      eaf = (ea == 8'd0) ? 8'd1 : ea;
      ebf = (eb == 8'd0) ? 8'd1 : eb;
      ma = {ea != 8'd0, a[22:0]};
      mb = {eb != 8'd0, b[22:0]};
      nan_a = (ea == 8'hFF) && (a[22:0] != 23'd0);
      nan_b = (eb == 8'hFF) && (b[22:0] != 23'd0);
      inf_a = (ea == 8'hFF) && (a[22:0] == 23'd0);
      inf_b = (eb == 8'hFF) && (b[22:0] == 23'd0);
      zero_a = (a[30:0] == 31'd0);
      zero_b = (b[30:0] == 31'd0);
      prod = '0;
      pw = '0;
      lz = '0;
      ex = '0;
      bigw = '0;
      smw = '0;
      sm = '0;
      mask = '0;
      sum = '0;
      norm = '0;
      st = 1'b0;
      sx = sa;
      sy = sb;
      exf = eaf;
      eyf = ebf;
      mx = ma;
      my = mb;
      d = '0;
      y = FP_QNAN;
      if (nan_a) begin
         y = a | 32'h0040_0000;
      end else if (nan_b) begin
         y = b | 32'h0040_0000;
      end else if (op == FP_MUL) begin
         if ((inf_a && zero_b) || (zero_a && inf_b)) y = FP_QNAN;
         else if (inf_a || inf_b) y = {sa ^ sb, 8'hFF, 23'h0};
         else if (zero_a || zero_b) y = {sa ^ sb, 31'h0};
         else begin
            prod = ma * mb;
            pw = {prod, 2'b00};
            lz = lzc50(pw);
            norm = pw << lz;
            ex = $signed({4'b0, eaf}) + $signed({4'b0, ebf}) - 12'sd126
                 - $signed({6'b0, lz});
            y = round_pack(sa ^ sb, ex, norm[49:2], 1'b0);
         end
      end else begin
         if (inf_a && inf_b && (sa != sb)) y = FP_QNAN;
         else if (inf_a) y = a;
         else if (inf_b) y = b;
         else if (zero_a && zero_b) y = {sa & sb, 31'h0};
         else if (zero_a) y = b;
         else if (zero_b) y = a;
         else begin
            if (b[30:0] > a[30:0]) begin
               sx = sb; sy = sa; exf = ebf; eyf = eaf; mx = mb; my = ma;
            end
            d = exf - eyf;
            bigw = {1'b0, mx, 25'h0};
            smw = {1'b0, my, 25'h0};
            if (d >= 8'd50) begin
               sm = '0;
               st = 1'b1;
            end else begin
               mask = (50'd1 << d[5:0]) - 50'd1;
               st = |(smw & mask);
               sm = smw >> d[5:0];
            end
            sm[0] = sm[0] | st;
            sum = (sx == sy) ? (bigw + sm) : (bigw - sm);
            if (sum == 50'd0) begin
               y = FP_ZERO;
            end else begin
               lz = lzc50(sum);
               norm = sum << lz;
               ex = $signed({4'b0, exf}) + 12'sd1 - $signed({6'b0, lz});
               y = round_pack(sx, ex, norm[49:2], |norm[1:0]);
            end
         end
      end
   end

endmodule

// ----- rtl/matrix_register_unit_4x4.sv -----
// Top level of the 4x4 single-precision matrix register unit.
// Depends on mru_pkg and on the shared float unit mru_fpu.
//
//   channel | dir | tdata (low bit up)                          | side bands
//   req     | in  | column, elem0, elem1, elem2, elem3, zeros  | tuser = req_type
//   rsp     | out | out_column, out_elem0..out_elem3, zeros    | tlast = last
//
// Identity, load and stage requests are written when they are accepted. A readout
// delivers four output words, each held until the consumer takes it.
// An apply computes each result element with four multiplies and three adds
// through the one shared float unit, then copies the result into the matrix.
// Reset is synchronous and active high; it sets the matrix to identity.
// The request side is not ready while an apply or a readout is in progress.
module matrix_register_unit_4x4 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // column[1:0], elem0[33:2], elem1[65:34], elem2[97:66], elem3[129:98]
   input  logic [mru_pkg::WORD_W-1:0]    req_tdata,
   // req_type[2:0]
   input  logic [2:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // out_column[1:0], out_elem0[33:2], out_elem1[65:34], out_elem2[97:66],
   // out_elem3[129:98]
   output logic [mru_pkg::WORD_W-1:0]    rsp_tdata,
   output logic                          rsp_tlast
);
   import mru_pkg::*;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       col_ff, col_in, row_ff, row_in, k_ff, k_in;
   logic [31:0]            acc_ff, acc_in, prod_ff, prod_in;
   logic [31:0]            x_ff [ENTRIES];
   logic [31:0]            m_ff [ENTRIES];
   logic [31:0]            r_ff [ENTRIES];
   logic                   rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [WORD_W-1:0]      rsp_data_ff, rsp_data_in;
   fp_op_type              fp_op;
   logic [31:0]            fp_a, fp_b, fp_y;
   logic                   req_fire, rsp_fire, res_we;
   logic [IDX_W-1:0]       req_col, rd_col;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_valid_ff && rsp_tready;
   assign req_col = req_tdata[IDX_W-1:0];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

   // The shared unit multiplies X by M entries, or adds a product to the sum.
   assign fp_op = (state_ff == ST_MUL) ? FP_MUL : FP_ADD;
   assign fp_a = (state_ff == ST_MUL) ? x_ff[{k_ff, row_ff}] : acc_ff;
   assign fp_b = (state_ff == ST_MUL) ? m_ff[{col_ff, k_ff}] : prod_ff;

   mru_fpu u_fpu (
      .op (fp_op),
      .a  (fp_a),
      .b  (fp_b),
      .y  (fp_y)
   );

   always_comb begin
      state_in = state_ff;
      col_in = col_ff;
      row_in = row_ff;
      k_in = k_ff;
      acc_in = acc_ff;
      prod_in = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in = rsp_last_ff;
      res_we = 1'b0;
      rd_col = col_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == REQ_READ)) begin
               rd_col = '0;
               col_in = '0;
               rsp_valid_in = 1'b1;
               rsp_last_in = 1'b0;
               state_in = ST_OUT;
            end else if (req_fire && (req_tuser == REQ_APPLY)) begin
               col_in = '0;
               row_in = '0;
               k_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (k_ff == '0) begin
               // The first product starts the running sum.
               acc_in = fp_y;
               k_in = k_ff + 1'b1;
            end else begin
               prod_in = fp_y;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            acc_in = fp_y;
            state_in = ST_MUL;
            if (k_ff == IDX_W'(DIM - 1)) begin
               res_we = 1'b1;
               k_in = '0;
               row_in = row_ff + 1'b1;
               if (row_ff == IDX_W'(DIM - 1)) begin
                  col_in = col_ff + 1'b1;
                  if (col_ff == IDX_W'(DIM - 1)) state_in = ST_COPY;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               if (col_ff == IDX_W'(DIM - 1)) begin
                  rsp_valid_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  rd_col = col_ff + 1'b1;
                  col_in = rd_col;
                  rsp_last_in = (rd_col == IDX_W'(DIM - 1));
               end
            end
         end
         ST_COPY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_data_in = {6'd0, x_ff[{rd_col, 2'd3}], x_ff[{rd_col, 2'd2}],
                     x_ff[{rd_col, 2'd1}], x_ff[{rd_col, 2'd0}], rd_col};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff <= 1'b0;
         col_ff <= '0;
         row_ff <= '0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff <= rsp_last_in;
         col_ff <= col_in;
         row_ff <= row_in;
         k_ff <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      if ((state_ff == ST_IDLE) && (state_in == ST_OUT)) rsp_data_ff <= rsp_data_in;
      else if ((state_ff == ST_OUT) && rsp_fire) rsp_data_ff <= rsp_data_in;
      if (res_we) r_ff[{col_ff, row_ff}] <= fp_y;
      if (req_fire && (req_tuser == REQ_STAGE)) begin
         for (int r = 0; r < DIM; r++) begin
            m_ff[{req_col, IDX_W'(r)}] <= req_tdata[IDX_W + 32*r +: 32];
         end
      end
   end

   // The current matrix resets to identity, like the identity request.
   always_ff @(posedge clock) begin
      if (reset || (req_fire && (req_tuser == REQ_IDENTITY))) begin
         for (int i = 0; i < ENTRIES; i++) begin
            x_ff[i] <= ((i / DIM) == (i % DIM)) ? FP_ONE : FP_ZERO;
         end
      end else if (req_fire && (req_tuser == REQ_LOAD)) begin
         for (int r = 0; r < DIM; r++) begin
            x_ff[{req_col, IDX_W'(r)}] <= req_tdata[IDX_W + 32*r +: 32];
         end
      end else if (state_ff == ST_COPY) begin
         for (int i = 0; i < ENTRIES; i++) begin
            x_ff[i] <= r_ff[i];
         end
      end
   end

endmodule

// ----- rtl/mru_checker.sv -----
// Port-level checker for the matrix register unit, bound to its top level.
// Depends on mru_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module mru_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [2:0]                 req_tuser,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [mru_pkg::WORD_W-1:0] rsp_tdata,
   input logic                       rsp_tlast
);
   import mru_pkg::*;

   // A waiting result word is not withdrawn.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // No request is taken while a readout is still being delivered.
   `ASSERT_IMPLY(a_busy_out, clock, reset, rsp_tvalid, !req_tready)
   // An apply keeps the request side closed on the next cycle.
   `ASSERT_NEXT(a_apply_busy, clock, reset,
      req_tvalid && req_tready && (req_tuser == REQ_APPLY), !req_tready)
   // A readout opens with column zero, not flagged as last.
   `ASSERT_NEXT(a_read_start, clock, reset,
      req_tvalid && req_tready && (req_tuser == REQ_READ),
      rsp_tvalid && (rsp_tdata[1:0] == 2'd0) && !rsp_tlast)

endmodule

bind matrix_register_unit_4x4 mru_checker u_mru_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
